/* rtl/nearest_neighbor_scaler_macros.svh */
// Assertion shorthands for the scaler checker.
`ifndef NEAREST_NEIGHBOR_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NNS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> cons) else $error(msg);

// Next-cycle implication, off while reset is high.
`define NNS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays live through reset.
`define NNS_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/nns_pkg.sv */
package nns_pkg;

  localparam int SRC_WIDTH_MAX  = 512;
  localparam int SRC_HEIGHT_MAX = 256;
  localparam int DST_MAX        = 4096;

  localparam int FRAC_BITS = 16;

  // source geometry
  localparam int COL_W  = $clog2(SRC_WIDTH_MAX);
  localparam int ROW_W  = $clog2(SRC_HEIGHT_MAX);
  localparam int SW_W   = COL_W + 1;
  localparam int SH_W   = ROW_W + 1;
  localparam int SZ_W   = (SW_W > SH_W) ? SW_W : SH_W;
  localparam int ADDR_W = $clog2(SRC_WIDTH_MAX * SRC_HEIGHT_MAX);

  // destination / canvas geometry
  localparam int COORD_W      = 12;
  localparam int DST_W        = $clog2(DST_MAX);
  localparam int DCMP_W       = (DST_W > COORD_W) ? DST_W : COORD_W;
  localparam int SCMP_W       = (SW_W > COORD_W) ? SW_W : COORD_W;
  localparam int HCMP_W       = (SH_W > COORD_W) ? SH_W : COORD_W;
  localparam int OFS_W        = 13;
  localparam int POS_W        = OFS_W + 1;
  localparam int CANVAS_W     = 13;
  localparam int CANVAS_LIMIT = 4096;
  localparam int PIX_W        = 8;

  // 10.16 step and 22.16 mapping product
  localparam int STEP_W    = SZ_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(STEP_W);
  localparam int PROD_W    = COORD_W + STEP_W;
  localparam int IDX_W     = PROD_W - FRAC_BITS;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = (DST_W > CANVAS_W) ? DST_W : CANVAS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_DST_WIDTH     = 3'd2,
    REG_DST_HEIGHT    = 3'd3,
    REG_DST_OFFSET_X  = 3'd4,
    REG_DST_OFFSET_Y  = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } cfg_reg_t;

  // reset values
  localparam int RST_SRC_WIDTH     = 320;
  localparam int RST_SRC_HEIGHT    = 200;
  localparam int RST_DST_WIDTH     = 320;
  localparam int RST_DST_HEIGHT    = 200;
  localparam int RST_CANVAS_WIDTH  = 320;
  localparam int RST_CANVAS_HEIGHT = 200;

  localparam logic [STEP_W-1:0] RST_X_STEP =
    STEP_W'((RST_SRC_WIDTH << FRAC_BITS) / RST_DST_WIDTH);
  localparam logic [STEP_W-1:0] RST_Y_STEP =
    STEP_W'((RST_SRC_HEIGHT << FRAC_BITS) / RST_DST_HEIGHT);

endpackage

/* rtl/nearest_neighbor_scaler.sv */
// Nearest-neighbor scaler for 8-bit indexed pixels with 10.16 step ratios.
// A command is taken on any clock where start is high and busy is low, one
// per clock. action 0 stores pixel_in at source (coord_x, coord_y); action 1
// maps output (coord_x, coord_y) of the destination rectangle back to a
// source pixel and returns it with its canvas position, or visible = 0 when
// the point is outside the rectangle or clipped by the canvas. Every command
// gives exactly one result word, marked by a one-cycle strobe after the
// command has passed s1 to s4; the result ports cannot be held off, so the
// consumer must take each word on its strobe. Writes report all zeros.
// Fetches and writes go through the source RAM in command order, so a fetch
// right behind a write sees the new pixel. A config write is taken on any
// clock (cfg_ready is always high) and restarts the step dividers: busy then
// stays high through the load state and then the run state, one quotient
// bit per clock of the 26-bit step. Source entries hold nothing until written.
module nearest_neighbor_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action,
  input  logic [nns_pkg::COORD_W-1:0]          coord_x,
  input  logic [nns_pkg::COORD_W-1:0]          coord_y,
  input  logic [nns_pkg::PIX_W-1:0]            pixel_in,
  output logic                                 strobe,
  output logic [nns_pkg::PIX_W-1:0]            pixel_value,
  output logic [nns_pkg::COORD_W-1:0]          canvas_x,
  output logic [nns_pkg::COORD_W-1:0]          canvas_y,
  output logic                                 visible,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [nns_pkg::CFG_W-1:0]            cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers (source and canvas sizes stored pre-clamped)
  // ---------------------------------------------------------------------
  logic [nns_pkg::SW_W-1:0]            src_w;
  logic [nns_pkg::SH_W-1:0]            src_h;
  logic [nns_pkg::DST_W-1:0]           dst_w;
  logic [nns_pkg::DST_W-1:0]           dst_h;
  logic signed [nns_pkg::OFS_W-1:0]    ofs_x;
  logic signed [nns_pkg::OFS_W-1:0]    ofs_y;
  logic [nns_pkg::CANVAS_W-1:0]        cvs_w;
  logic [nns_pkg::CANVAS_W-1:0]        cvs_h;

  logic cfg_wr;

  function automatic logic [nns_pkg::SW_W-1:0] clamp_sw(input logic [nns_pkg::SW_W-1:0] v);
    logic [nns_pkg::SW_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = nns_pkg::SW_W'(1);
    end else if (v > nns_pkg::SW_W'(nns_pkg::SRC_WIDTH_MAX)) begin
      r = nns_pkg::SW_W'(nns_pkg::SRC_WIDTH_MAX);
    end
    return r;
  endfunction

  function automatic logic [nns_pkg::SH_W-1:0] clamp_sh(input logic [nns_pkg::SH_W-1:0] v);
    logic [nns_pkg::SH_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = nns_pkg::SH_W'(1);
    end else if (v > nns_pkg::SH_W'(nns_pkg::SRC_HEIGHT_MAX)) begin
      r = nns_pkg::SH_W'(nns_pkg::SRC_HEIGHT_MAX);
    end
    return r;
  endfunction

  function automatic logic [nns_pkg::CANVAS_W-1:0] clamp_cvs(
    input logic [nns_pkg::CANVAS_W-1:0] v
  );
    logic [nns_pkg::CANVAS_W-1:0] r;
    r = v;
    if (v > nns_pkg::CANVAS_W'(nns_pkg::CANVAS_LIMIT)) begin
      r = nns_pkg::CANVAS_W'(nns_pkg::CANVAS_LIMIT);
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= nns_pkg::SW_W'(nns_pkg::RST_SRC_WIDTH);
      src_h <= nns_pkg::SH_W'(nns_pkg::RST_SRC_HEIGHT);
      dst_w <= nns_pkg::DST_W'(nns_pkg::RST_DST_WIDTH);
      dst_h <= nns_pkg::DST_W'(nns_pkg::RST_DST_HEIGHT);
      ofs_x <= '0;
      ofs_y <= '0;
      cvs_w <= nns_pkg::CANVAS_W'(nns_pkg::RST_CANVAS_WIDTH);
      cvs_h <= nns_pkg::CANVAS_W'(nns_pkg::RST_CANVAS_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        nns_pkg::REG_SRC_WIDTH:     src_w <= clamp_sw(cfg_data[nns_pkg::SW_W-1:0]);
        nns_pkg::REG_SRC_HEIGHT:    src_h <= clamp_sh(cfg_data[nns_pkg::SH_W-1:0]);
        nns_pkg::REG_DST_WIDTH:     dst_w <= cfg_data[nns_pkg::DST_W-1:0];
        nns_pkg::REG_DST_HEIGHT:    dst_h <= cfg_data[nns_pkg::DST_W-1:0];
        nns_pkg::REG_DST_OFFSET_X:  ofs_x <= $signed(cfg_data[nns_pkg::OFS_W-1:0]);
        nns_pkg::REG_DST_OFFSET_Y:  ofs_y <= $signed(cfg_data[nns_pkg::OFS_W-1:0]);
        nns_pkg::REG_CANVAS_WIDTH:  cvs_w <= clamp_cvs(cfg_data[nns_pkg::CANVAS_W-1:0]);
        nns_pkg::REG_CANVAS_HEIGHT: cvs_h <= clamp_cvs(cfg_data[nns_pkg::CANVAS_W-1:0]);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Step dividers: x_step = (src_w << 16) / dst_w, same for y.
  // Two restoring dividers share one bit counter, one quotient bit a clock.
  // The dividend register shifts the quotient in from the bottom.
  // ---------------------------------------------------------------------
  typedef enum logic [1:0] {DIV_IDLE, DIV_LOAD, DIV_RUN} div_state_t;

  localparam logic [nns_pkg::DIV_CNT_W-1:0] DIV_LAST =
    nns_pkg::DIV_CNT_W'(nns_pkg::STEP_W - 1);

  div_state_t                    div_state;
  logic [nns_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [nns_pkg::STEP_W-1:0]    x_num, y_num;
  logic [nns_pkg::DST_W-1:0]     x_rem, y_rem;
  logic [nns_pkg::STEP_W-1:0]    x_step, y_step;

  logic [nns_pkg::DST_W:0]       x_trial, y_trial;
  logic                          x_ge, y_ge;
  logic [nns_pkg::DST_W-1:0]     x_rem_next, y_rem_next;
  logic [nns_pkg::STEP_W-1:0]    x_num_next, y_num_next;

  always_comb begin
    x_trial    = {x_rem, x_num[nns_pkg::STEP_W-1]};
    y_trial    = {y_rem, y_num[nns_pkg::STEP_W-1]};
    x_ge       = x_trial >= {1'b0, dst_w};
    y_ge       = y_trial >= {1'b0, dst_h};
    x_rem_next = x_ge ? nns_pkg::DST_W'(x_trial - {1'b0, dst_w}) : x_trial[nns_pkg::DST_W-1:0];
    y_rem_next = y_ge ? nns_pkg::DST_W'(y_trial - {1'b0, dst_h}) : y_trial[nns_pkg::DST_W-1:0];
    x_num_next = {x_num[nns_pkg::STEP_W-2:0], x_ge};
    y_num_next = {y_num[nns_pkg::STEP_W-2:0], y_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
      div_cnt   <= '0;
      x_step    <= nns_pkg::RST_X_STEP;
      y_step    <= nns_pkg::RST_Y_STEP;
    end else if (cfg_wr) begin
      // registers settle this clock; load dividers on the next
      div_state <= DIV_LOAD;
    end else begin
      unique case (div_state)
        DIV_IDLE: begin
        end
        DIV_LOAD: begin
          x_num     <= nns_pkg::STEP_W'(src_w) << nns_pkg::FRAC_BITS;
          y_num     <= nns_pkg::STEP_W'(src_h) << nns_pkg::FRAC_BITS;
          x_rem     <= '0;
          y_rem     <= '0;
          div_cnt   <= '0;
          div_state <= DIV_RUN;
        end
        DIV_RUN: begin
          x_num   <= x_num_next;
          y_num   <= y_num_next;
          x_rem   <= x_rem_next;
          y_rem   <= y_rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            // zero size gives a zero step
            x_step    <= (dst_w == '0) ? '0 : x_num_next;
            y_step    <= (dst_h == '0) ? '0 : y_num_next;
            div_state <= DIV_IDLE;
          end
        end
      endcase
    end
  end

  assign busy = (div_state != DIV_IDLE);

  // ---------------------------------------------------------------------
  // Command pipeline
  //   s1: registered command
  //   s2: scaled source index (multiply), clip and range checks
  //   s3: clamped row/column, RAM enables
  //   s4: RAM address (row * pitch + col)
  //   out: RAM access, result word
  // ---------------------------------------------------------------------
  logic                          accept;
  assign accept = start && !busy;

  // s1
  logic                          s1_vld, s1_act;
  logic [nns_pkg::COORD_W-1:0]   s1_cx, s1_cy;
  logic [nns_pkg::PIX_W-1:0]     s1_pix;

  // s1 -> s2 logic
  logic [nns_pkg::PROD_W-1:0]    prod_x, prod_y;
  logic signed [nns_pkg::POS_W-1:0] pos_x, pos_y;
  logic                          in_rect, on_cvs, wr_ok;

  always_comb begin
    prod_x  = nns_pkg::PROD_W'(s1_cx) * nns_pkg::PROD_W'(x_step);
    prod_y  = nns_pkg::PROD_W'(s1_cy) * nns_pkg::PROD_W'(y_step);
    in_rect = (nns_pkg::DCMP_W'(s1_cx) < nns_pkg::DCMP_W'(dst_w)) &&
              (nns_pkg::DCMP_W'(s1_cy) < nns_pkg::DCMP_W'(dst_h));
    pos_x   = nns_pkg::POS_W'(ofs_x) + $signed(nns_pkg::POS_W'(s1_cx));
    pos_y   = nns_pkg::POS_W'(ofs_y) + $signed(nns_pkg::POS_W'(s1_cy));
    on_cvs  = !pos_x[nns_pkg::POS_W-1] && (pos_x[nns_pkg::POS_W-2:0] < cvs_w) &&
              !pos_y[nns_pkg::POS_W-1] && (pos_y[nns_pkg::POS_W-2:0] < cvs_h);
    wr_ok   = (nns_pkg::SCMP_W'(s1_cx) < nns_pkg::SCMP_W'(src_w)) &&
              (nns_pkg::HCMP_W'(s1_cy) < nns_pkg::HCMP_W'(src_h));
  end

  // s2
  logic                          s2_vld, s2_act, s2_vis, s2_wok;
  logic [nns_pkg::COORD_W-1:0]   s2_px, s2_py;
  logic [nns_pkg::IDX_W-1:0]     s2_sx, s2_sy;
  logic [nns_pkg::COL_W-1:0]     s2_col;
  logic [nns_pkg::ROW_W-1:0]     s2_row;
  logic [nns_pkg::PIX_W-1:0]     s2_pix;

  // s2 -> s3 logic: clamp the scaled index to the source edge
  logic [nns_pkg::COL_W-1:0]     sx_cl;
  logic [nns_pkg::ROW_W-1:0]     sy_cl;

  always_comb begin
    sx_cl = s2_sx[nns_pkg::COL_W-1:0];
    sy_cl = s2_sy[nns_pkg::ROW_W-1:0];
    if (s2_sx >= nns_pkg::IDX_W'(src_w)) begin
      sx_cl = nns_pkg::COL_W'(src_w - 1'b1);
    end
    if (s2_sy >= nns_pkg::IDX_W'(src_h)) begin
      sy_cl = nns_pkg::ROW_W'(src_h - 1'b1);
    end
  end

  // s3
  logic                          s3_vld, s3_we, s3_re, s3_vis;
  logic [nns_pkg::COORD_W-1:0]   s3_px, s3_py;
  logic [nns_pkg::COL_W-1:0]     s3_col;
  logic [nns_pkg::ROW_W-1:0]     s3_row;
  logic [nns_pkg::PIX_W-1:0]     s3_pix;

  // s3 -> s4 logic: row-major address, pitch = source width
  logic [nns_pkg::ROW_W+nns_pkg::SW_W-1:0] row_base;
  logic [nns_pkg::ADDR_W-1:0]              addr;

  always_comb begin
    row_base = (nns_pkg::ROW_W + nns_pkg::SW_W)'(s3_row) *
               (nns_pkg::ROW_W + nns_pkg::SW_W)'(src_w);
    addr     = nns_pkg::ADDR_W'(row_base) + nns_pkg::ADDR_W'(s3_col);
  end

  // s4
  logic                          s4_vld, s4_we, s4_re, s4_vis;
  logic [nns_pkg::COORD_W-1:0]   s4_px, s4_py;
  logic [nns_pkg::ADDR_W-1:0]    s4_addr;
  logic [nns_pkg::PIX_W-1:0]     s4_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s2_vis <= 1'b0;
      s3_vld <= 1'b0;
      s3_we  <= 1'b0;
      s3_re  <= 1'b0;
      s3_vis <= 1'b0;
      s4_vld <= 1'b0;
      s4_we  <= 1'b0;
      s4_re  <= 1'b0;
      s4_vis <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s2_vis <= s1_vld && s1_act && in_rect && on_cvs;
      s3_vld <= s2_vld;
      s3_we  <= s2_vld && !s2_act && s2_wok;
      s3_re  <= s2_vld && s2_act && s2_vis;
      s3_vis <= s2_vld && s2_vis;
      s4_vld <= s3_vld;
      s4_we  <= s3_we;
      s4_re  <= s3_re;
      s4_vis <= s3_vis;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act <= action;
      s1_cx  <= coord_x;
      s1_cy  <= coord_y;
      s1_pix <= pixel_in;
    end
    s2_act  <= s1_act;
    s2_wok  <= wr_ok;
    s2_px   <= pos_x[nns_pkg::COORD_W-1:0];
    s2_py   <= pos_y[nns_pkg::COORD_W-1:0];
    s2_sx   <= prod_x[nns_pkg::PROD_W-1:nns_pkg::FRAC_BITS];
    s2_sy   <= prod_y[nns_pkg::PROD_W-1:nns_pkg::FRAC_BITS];
    s2_col  <= s1_cx[nns_pkg::COL_W-1:0];
    s2_row  <= s1_cy[nns_pkg::ROW_W-1:0];
    s2_pix  <= s1_pix;
    s3_px   <= s2_px;
    s3_py   <= s2_py;
    s3_col  <= s2_act ? sx_cl : s2_col;
    s3_row  <= s2_act ? sy_cl : s2_row;
    s3_pix  <= s2_pix;
    s4_px   <= s3_px;
    s4_py   <= s3_py;
    s4_addr <= addr;
    s4_pix  <= s3_pix;
  end

  // ---------------------------------------------------------------------
  // Source RAM: one write or one read per clock, registered read data
  // ---------------------------------------------------------------------
  logic [nns_pkg::PIX_W-1:0] src_mem [nns_pkg::SRC_WIDTH_MAX * nns_pkg::SRC_HEIGHT_MAX];
  logic [nns_pkg::PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (s4_we) begin
      src_mem[s4_addr] <= s4_pix;
    end
    if (s4_re) begin
      rd_data <= src_mem[s4_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Result word: all fields zero unless visible
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      visible  <= 1'b0;
      canvas_x <= '0;
      canvas_y <= '0;
    end else begin
      strobe   <= s4_vld;
      visible  <= s4_vis;
      canvas_x <= s4_vis ? s4_px : '0;
      canvas_y <= s4_vis ? s4_py : '0;
    end
  end

  assign pixel_value = visible ? rd_data : '0;

endmodule

/* rtl/nns_checker.sv */
`include "nearest_neighbor_scaler_macros.svh"

module nns_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic                        visible,
  input logic [nns_pkg::PIX_W-1:0]   pixel_value,
  input logic [nns_pkg::COORD_W-1:0] canvas_x,
  input logic [nns_pkg::COORD_W-1:0] canvas_y,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  // every accepted command gives its result word on a strobe
  `NNS_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##5 strobe, "result word missing after command")

  // a visible pixel only ever rides on a strobe
  `NNS_ASSERT_IMPL(a_vis_strobe, clk, rst, visible, strobe, "visible without strobe")

  // hidden or write words carry all-zero payload
  `NNS_ASSERT_IMPL(a_zero_hidden, clk, rst, !visible, (pixel_value == '0 && canvas_x == '0 && canvas_y == '0), "nonzero payload on hidden word")

  // a config write holds off commands while the steps are recomputed
  `NNS_ASSERT_NEXT(a_cfg_busy, clk, rst, cfg_valid && cfg_ready, busy, "not busy after config write")

  // reset leaves no word in flight and the dividers idle
  `NNS_ASSERT_ALWAYS(a_rst_quiet, clk, rst, !strobe && !busy, "strobe or busy after reset")

endmodule

bind nearest_neighbor_scaler nns_checker u_nns_checker (.*);
